// File: hw/rtl/nptf_pkg.sv
// Shared constants, types and codes for the NoC packet trace framer.
`default_nettype none

package nptf_pkg;

    // Store geometry.
    localparam int NUM_LINKS = 8;
    localparam int MAX_FLITS = 32;
    localparam int LINK_W    = 3;
    localparam int IDX_W     = $clog2(MAX_FLITS);
    localparam int CNT_W     = $clog2(MAX_FLITS + 1);
    localparam int ADDR_W    = $clog2(NUM_LINKS * MAX_FLITS);

    // Stream widths.
    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 152;

    // Header class codes.
    localparam logic [2:0] CLS_MESSAGE = 3'd0;
    localparam logic [2:0] CLS_CONTROL = 3'd7;

    // Event identifiers carried in each trace record.
    localparam logic [1:0] EV_UNKNOWN   = 2'd0;
    localparam logic [1:0] EV_CTRL_REQ  = 2'd1;
    localparam logic [1:0] EV_CTRL_RESP = 2'd2;
    localparam logic [1:0] EV_MESSAGE   = 2'd3;

    // Record sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_EMIT
    } t_state;

    // One cycle of requests to the flit store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// File: hw/rtl/nptf_flit_ram.sv
// Flit store: single write port, single registered read port.
`default_nettype none

module nptf_flit_ram (
    input  wire logic              i_clk,
    input  wire nptf_pkg::t_ram_req i_req,
    output logic [31:0]            o_rd_data
);
    import nptf_pkg::*;

    logic [31:0] r_mem [NUM_LINKS * MAX_FLITS];
    logic [31:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, data held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/noc_packet_trace_framer.sv
// Top level of the NoC packet trace framer.
//
// Input stream: one flit per transaction, with its link, word and timestamp in
// tdata and the end-of-packet mark in tlast. Flits are stored per link in a
// 256-word memory; a flit arriving when its link already holds the maximum
// number of flits is dropped and the packet is flagged as overflowed.
// Non-last flits, taken one per cycle while the sequencer is idle, give no output.
// When a last flit is accepted, input ready drops and a sequencer reads the
// packet back from the store: it first fetches the header, then gives one
// output transaction per cycle while the receiver is ready (head record, then
// one per payload flit; a control packet gives a single word). The header read
// is issued from the state after the last flit, and the first record word is
// then registered in the output stage. Input ready stays low until the last
// word of a record is loaded, so no flit is taken while a record is read out.
// Output stream: one record word per transaction, tlast marks the final word
// of a record and tuser tells a payload word from a record head.
// A registered output stage lets new flits be accepted while the last word of
// a record waits. When the receiver stalls, the sequencer holds its position.
// Reset clears all per-link counts and overflow flags; the store needs no
// clearing since only entries written by the current packet are read.
`default_nettype none

module noc_packet_trace_framer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input flit: link[2:0], flit[34:3], timestamp[98:35], zero pad.
    input  wire logic [nptf_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Record word: event_id[1:0], time_stamp[65:2], link_index[68:66],
    // source_tile[73:69], dest_tile[78:74], header_word[110:79],
    // payload_length[115:111], resp_status[116], payload_word[148:117],
    // overflow[149], zero pad.
    output logic [nptf_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    // Record word kind: is_payload[0].
    output logic                               o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready
);
    import nptf_pkg::*;

    // Input field unpacking.
    logic [LINK_W-1:0] in_link;
    logic [31:0]       in_flit;
    logic [63:0]       in_ts;

    assign in_link = i_s_axis_tdata[2:0];
    assign in_flit = i_s_axis_tdata[34:3];
    assign in_ts   = i_s_axis_tdata[98:35];

    // Per-link state.
    logic [CNT_W-1:0] r_flit_cnt [NUM_LINKS];
    logic             r_ovf_mark [NUM_LINKS];

    // Sequencer and record context.
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_rec_cnt;
    logic             r_rec_ovf;
    logic [63:0]      r_ts;
    logic [LINK_W-1:0] r_link;
    logic [31:0]      r_hdr;

    // Output stage.
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_user;
    logic                r_out_last;

    // Store interface.
    t_ram_req    ram_req;
    logic [31:0] rd_data;

    nptf_flit_ram u_flit_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Intake decode.
    logic             s_fire;
    logic             in_range;
    logic [CNT_W-1:0] cur_cnt;
    logic             can_store;

    assign s_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_range  = 32'(in_link) < NUM_LINKS;
    assign cur_cnt   = r_flit_cnt[in_link];
    assign can_store = 32'(cur_cnt) < MAX_FLITS;

    // Record word formation.
    logic              out_free;
    logic [31:0]       hdr_cur;
    logic [2:0]        hdr_cls;
    logic              is_ctrl;
    logic              rec_done;
    logic [1:0]        ev_id;
    logic [4:0]        pay_len;
    logic              resp_st;
    logic              is_pay;
    logic [31:0]       pay_word;
    logic [CNT_W-1:0]  idx_next;
    logic              out_load;
    logic [M_DATA_W-1:0] rec_data;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign hdr_cur  = (r_idx == '0) ? rd_data : r_hdr;
    assign hdr_cls  = hdr_cur[26:24];
    assign is_ctrl  = hdr_cls == CLS_CONTROL;
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign rec_done = is_ctrl || (idx_next == r_rec_cnt);
    assign is_pay   = r_idx != '0;
    assign pay_word = is_pay ? rd_data : 32'd0;
    assign pay_len  = is_ctrl ? 5'd0 : 5'(r_rec_cnt - CNT_W'(1));
    assign resp_st  = is_ctrl && hdr_cur[0] && hdr_cur[1];

    // Event classification from the header class bits.
    always_comb begin
        case (hdr_cls)
            CLS_CONTROL: ev_id = hdr_cur[0] ? EV_CTRL_RESP : EV_CTRL_REQ;
            CLS_MESSAGE: ev_id = EV_MESSAGE;
            default:     ev_id = EV_UNKNOWN;
        endcase
    end

    assign rec_data = {2'b00, r_rec_ovf, pay_word, resp_st, pay_len, hdr_cur,
                       hdr_cur[31:27], hdr_cur[23:19], r_link, r_ts, ev_id};

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire && in_range && i_s_axis_tlast) begin
                    n_state = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && rec_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: handshake and store requests.
    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = ADDR_W'(in_link) * ADDR_W'(MAX_FLITS) + ADDR_W'(cur_cnt);
        ram_req.wdata   = in_flit;
        ram_req.re      = 1'b0;
        ram_req.raddr   = ADDR_W'(r_link) * ADDR_W'(MAX_FLITS);
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                ram_req.we      = i_s_axis_tvalid && in_range && can_store;
            end
            ST_HEAD_RD: begin
                ram_req.re = 1'b1;
            end
            ST_EMIT: begin
                out_load      = out_free;
                ram_req.re    = out_free && !rec_done;
                ram_req.raddr = ADDR_W'(r_link) * ADDR_W'(MAX_FLITS)
                              + ADDR_W'(idx_next);
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // Per-link counts and overflow flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LINKS; k++) begin
                r_flit_cnt[k] <= '0;
                r_ovf_mark[k] <= 1'b0;
            end
        end else if (s_fire && in_range) begin
            if (i_s_axis_tlast) begin
                r_flit_cnt[in_link] <= '0;
                r_ovf_mark[in_link] <= 1'b0;
            end else if (can_store) begin
                r_flit_cnt[in_link] <= cur_cnt + CNT_W'(1);
            end else begin
                r_ovf_mark[in_link] <= 1'b1;
            end
        end
    end

    // Sequencer state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Record context and output payload.
    always_ff @(posedge i_clk) begin
        if (s_fire && in_range && i_s_axis_tlast) begin
            r_rec_cnt <= can_store ? cur_cnt + CNT_W'(1) : cur_cnt;
            r_rec_ovf <= r_ovf_mark[in_link] || !can_store;
            r_ts      <= in_ts;
            r_link    <= in_link;
        end
        if (r_state == ST_HEAD_RD) begin
            r_idx <= '0;
        end else if (out_load) begin
            r_idx <= IDX_W'(idx_next);
        end
        if (out_load && !is_pay) begin
            r_hdr <= rd_data;
        end
        if (out_load) begin
            r_out_data <= rec_data;
            r_out_user <= is_pay;
            r_out_last <= rec_done;
        end
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tvalid = r_out_valid;

    // A closed packet always leaves its link empty and starts a header fetch.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && in_range && i_s_axis_tlast
        |=> r_state == ST_HEAD_RD && r_flit_cnt[$past(in_link)] == '0)
        else $error("packet close did not clear link state");

    // A record being read back holds at least its header and at most MAX_FLITS flits.
    a_rec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_rec_cnt != '0 && 32'(r_rec_cnt) <= MAX_FLITS)
        else $error("record flit count out of range");

    // No payload read is issued in the emit state while the output stage is blocked.
    a_no_read_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && !out_free |-> !ram_req.re)
        else $error("store read issued while output is stalled");

endmodule

`default_nettype wire
